// ===== hw/rtl/bcar_pkg.sv =====
`timescale 1ns / 1ps

package bcar_pkg;

  // Default sizes of the processor and bank spaces.
  localparam int DEF_MAX_PROCESSORS = 64;
  localparam int DEF_MAX_BANKS      = 2048;

  // Fixed field widths.
  localparam int REQ_W    = 11;
  localparam int CNT_W    = 20;
  localparam int IDX_W    = 6;
  localparam int CFGP_W   = 7;
  localparam int CFGB_W   = 12;
  localparam int CFGIDX_W = 1;

  // Configuration register indexes.
  localparam logic [CFGIDX_W-1:0] CFG_PROCS = 1'b0;
  localparam logic [CFGIDX_W-1:0] CFG_BANKS = 1'b1;

  // Reset values of the configuration registers.
  localparam logic [CFGP_W-1:0] PROCS_RESET = 7'd64;
  localparam logic [CFGB_W-1:0] BANKS_RESET = 12'd2048;

  // Saturation value of the wait and grant counters.
  localparam logic [CNT_W-1:0] COUNT_MAX = 20'hFFFFF;

  // Per-processor state word.
  typedef struct packed {
    logic [REQ_W-1:0] held;
    logic [CNT_W-1:0] wait_cnt;
    logic [CNT_W-1:0] grant_cnt;
  } proc_word_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_CLR,
    S_LPREP,
    S_LOAD,
    S_ARD,
    S_ABUS,
    S_AUPD,
    S_ERD,
    S_ECAP
  } state_t;

endpackage

// ===== hw/rtl/bcar_ram.sv =====
`timescale 1ns / 1ps

module bcar_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/bank_conflict_arbiter_rotating_core.sv =====
`timescale 1ns / 1ps
// Each request is loaded as a state read, then an update. Arbitration then
// takes a state read, a bank busy read and an update per active processor, and
// the results follow, each as a state read and then a capture into the output.
// After reset the bank busy memory is cleared with in_stall high;
// control state, counters and held requests read as zero after reset.
module bank_conflict_arbiter_rotating_core #(
  parameter int MAX_PROCESSORS = bcar_pkg::DEF_MAX_PROCESSORS,
  parameter int MAX_BANKS      = bcar_pkg::DEF_MAX_BANKS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // Configuration port
  input  logic                          cfg_we,
  input  logic [bcar_pkg::CFGIDX_W-1:0] cfg_index,
  input  logic [bcar_pkg::CFGB_W-1:0]   cfg_wdata,
  // Request channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [bcar_pkg::REQ_W-1:0]    in_bank_request,
  input  logic                          in_end_of_cycle,
  // Result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [bcar_pkg::IDX_W-1:0]    out_processor_index,
  output logic                          out_grant,
  output logic [bcar_pkg::REQ_W-1:0]    out_bank_used,
  output logic [bcar_pkg::CNT_W-1:0]    out_wait_count,
  output logic [bcar_pkg::CNT_W-1:0]    out_grant_count,
  output logic                          out_last_result
);

  localparam int PW      = (MAX_PROCESSORS > 1) ? $clog2(MAX_PROCESSORS) : 1;
  localparam int PCW     = $clog2(MAX_PROCESSORS + 1);
  localparam int BW      = (MAX_BANKS > 1) ? $clog2(MAX_BANKS) : 1;
  localparam int BCW     = $clog2(MAX_BANKS + 1);
  localparam int PWORD_W = $bits(bcar_pkg::proc_word_t);
  localparam int RWORD_W = BW + 1;

  bcar_pkg::state_t state_r, state_nxt;

  logic [bcar_pkg::CFGP_W-1:0] cfg_procs_r;
  logic [bcar_pkg::CFGB_W-1:0] cfg_banks_r;

  logic [PW-1:0]             load_pos_r, load_pos_nxt;
  logic [PW-1:0]             start_r, start_nxt;
  logic [PW-1:0]             i_r, i_nxt;
  logic [PW-1:0]             cnt_r, cnt_nxt;
  logic [PW-1:0]             k_r, k_nxt;
  logic [PW-1:0]             fd_r, fd_nxt;
  logic                      any_den_r, any_den_nxt;
  logic [BW-1:0]             clr_r, clr_nxt;
  logic [MAX_PROCESSORS-1:0] vld_r, vld_nxt;
  logic                      vld_q_r, vld_q_nxt;
  bcar_pkg::proc_word_t      word_r, word_nxt;
  logic [BW-1:0]             bank_r, bank_nxt;

  logic                         out_valid_r, out_valid_nxt;
  logic [bcar_pkg::IDX_W-1:0]   out_idx_r, out_idx_nxt;
  logic                         out_grant_r, out_grant_nxt;
  logic [bcar_pkg::REQ_W-1:0]   out_bank_r, out_bank_nxt;
  logic [bcar_pkg::CNT_W-1:0]   out_wait_r, out_wait_nxt;
  logic [bcar_pkg::CNT_W-1:0]   out_gcnt_r, out_gcnt_nxt;
  logic                         out_last_r, out_last_nxt;

  logic [PCW-1:0] procs_eff;
  logic [BCW-1:0] banks_eff;
  logic [PW-1:0]  pos_eff;
  logic [PW-1:0]  start_eff;
  logic [BW-1:0]  bank_cl;
  logic           load_more;
  logic           i_last;
  logic           cnt_last;
  logic           k_last;
  logic           clr_last;
  logic           cap;
  logic           granted;

  // Per-processor state memory.
  logic                 pmem_we;
  logic [PW-1:0]        pmem_waddr;
  logic [PW-1:0]        pmem_raddr;
  bcar_pkg::proc_word_t pmem_wdata;
  logic [PWORD_W-1:0]   pmem_rdata;
  bcar_pkg::proc_word_t rword;

  // Per-processor arbitration outcome memory: {granted, bank}.
  logic               rmem_we;
  logic [RWORD_W-1:0] rmem_wdata;
  logic [RWORD_W-1:0] rmem_rdata;

  // Bank busy memory.
  logic          bmem_we;
  logic [BW-1:0] bmem_waddr;
  logic          bmem_wdata;
  logic [BW-1:0] bmem_raddr;
  logic          bmem_rdata;

  bcar_ram #(.WIDTH(PWORD_W), .DEPTH(MAX_PROCESSORS)) u_pmem (
    .clk   (clk),
    .we    (pmem_we),
    .waddr (pmem_waddr),
    .wdata (pmem_wdata),
    .raddr (pmem_raddr),
    .rdata (pmem_rdata)
  );

  bcar_ram #(.WIDTH(RWORD_W), .DEPTH(MAX_PROCESSORS)) u_rmem (
    .clk   (clk),
    .we    (rmem_we),
    .waddr (i_r),
    .wdata (rmem_wdata),
    .raddr (k_r),
    .rdata (rmem_rdata)
  );

  bcar_ram #(.WIDTH(1), .DEPTH(MAX_BANKS)) u_bmem (
    .clk   (clk),
    .we    (bmem_we),
    .waddr (bmem_waddr),
    .wdata (bmem_wdata),
    .raddr (bmem_raddr),
    .rdata (bmem_rdata)
  );

  // Configuration values saturated into their legal ranges.
  always_comb begin
    if (cfg_procs_r == '0) begin
      procs_eff = PCW'(1);
    end else if (32'(cfg_procs_r) > MAX_PROCESSORS) begin
      procs_eff = PCW'(MAX_PROCESSORS);
    end else begin
      procs_eff = PCW'(cfg_procs_r);
    end
    if (cfg_banks_r == '0) begin
      banks_eff = BCW'(1);
    end else if (32'(cfg_banks_r) > MAX_BANKS) begin
      banks_eff = BCW'(MAX_BANKS);
    end else begin
      banks_eff = BCW'(cfg_banks_r);
    end
  end

  // Load position and start pointer limited to the active processors.
  always_comb begin
    if (32'(load_pos_r) >= 32'(procs_eff)) begin
      pos_eff = PW'(procs_eff - 1'b1);
    end else begin
      pos_eff = load_pos_r;
    end
    if (32'(start_r) >= 32'(procs_eff)) begin
      start_eff = '0;
    end else begin
      start_eff = start_r;
    end
  end

  // A processor that was never written reads as all zero.
  assign rword = vld_q_r ? bcar_pkg::proc_word_t'(pmem_rdata) : '0;

  // A request at or beyond the active banks goes to the top active bank.
  always_comb begin
    if (32'(rword.held) >= 32'(banks_eff)) begin
      bank_cl = BW'(banks_eff - 1'b1);
    end else begin
      bank_cl = BW'(rword.held);
    end
  end

  assign load_more = !in_end_of_cycle && (32'(pos_eff) + 32'd1 < 32'(procs_eff));
  assign i_last    = (32'(i_r) + 32'd1 == 32'(procs_eff));
  assign cnt_last  = (32'(cnt_r) + 32'd1 == 32'(procs_eff));
  assign k_last    = (32'(k_r) + 32'd1 == 32'(procs_eff));
  assign clr_last  = (32'(clr_r) == MAX_BANKS - 1);
  assign cap       = !out_valid_r || !out_stall;
  assign granted   = !bmem_rdata;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bcar_pkg::S_CLR: begin
        if (clr_last) state_nxt = bcar_pkg::S_LPREP;
      end
      bcar_pkg::S_LPREP: state_nxt = bcar_pkg::S_LOAD;
      bcar_pkg::S_LOAD: begin
        if (in_valid) begin
          state_nxt = load_more ? bcar_pkg::S_LPREP : bcar_pkg::S_ARD;
        end
      end
      bcar_pkg::S_ARD:  state_nxt = bcar_pkg::S_ABUS;
      bcar_pkg::S_ABUS: state_nxt = bcar_pkg::S_AUPD;
      bcar_pkg::S_AUPD: state_nxt = cnt_last ? bcar_pkg::S_ERD : bcar_pkg::S_ARD;
      bcar_pkg::S_ERD:  state_nxt = bcar_pkg::S_ECAP;
      bcar_pkg::S_ECAP: begin
        if (cap) state_nxt = k_last ? bcar_pkg::S_LPREP : bcar_pkg::S_ERD;
      end
      default: state_nxt = bcar_pkg::S_CLR;
    endcase
  end

  // Memory controls and register next values.
  always_comb begin
    load_pos_nxt = load_pos_r;
    start_nxt    = start_r;
    i_nxt        = i_r;
    cnt_nxt      = cnt_r;
    k_nxt        = k_r;
    fd_nxt       = fd_r;
    any_den_nxt  = any_den_r;
    clr_nxt      = clr_r;
    word_nxt     = word_r;
    bank_nxt     = bank_r;

    out_valid_nxt = out_valid_r && out_stall;
    out_idx_nxt   = out_idx_r;
    out_grant_nxt = out_grant_r;
    out_bank_nxt  = out_bank_r;
    out_wait_nxt  = out_wait_r;
    out_gcnt_nxt  = out_gcnt_r;
    out_last_nxt  = out_last_r;

    pmem_we    = 1'b0;
    pmem_waddr = i_r;
    pmem_wdata = rword;
    pmem_raddr = pos_eff;
    rmem_we    = 1'b0;
    rmem_wdata = {granted, bank_r};
    bmem_we    = 1'b0;
    bmem_waddr = bank_r;
    bmem_wdata = 1'b0;
    bmem_raddr = bank_cl;

    case (state_r)
      // Clear the bank busy memory after reset.
      bcar_pkg::S_CLR: begin
        bmem_we    = 1'b1;
        bmem_waddr = clr_r;
        clr_nxt    = clr_r + 1'b1;
      end

      bcar_pkg::S_LPREP: begin
        pmem_raddr = pos_eff;
      end

      // Take a request; a waiting processor keeps its held request.
      bcar_pkg::S_LOAD: begin
        pmem_raddr = pos_eff;
        pmem_waddr = pos_eff;
        pmem_wdata = rword;
        pmem_wdata.held = in_bank_request;
        if (in_valid) begin
          pmem_we = (rword.wait_cnt == '0);
          if (load_more) begin
            load_pos_nxt = pos_eff + 1'b1;
          end else begin
            load_pos_nxt = '0;
            i_nxt        = start_eff;
            cnt_nxt      = '0;
            any_den_nxt  = 1'b0;
          end
        end
      end

      bcar_pkg::S_ARD: begin
        pmem_raddr = i_r;
      end

      // Processor state is in; look up whether its bank is taken.
      bcar_pkg::S_ABUS: begin
        pmem_raddr = i_r;
        bmem_raddr = bank_cl;
        word_nxt   = rword;
        bank_nxt   = bank_cl;
      end

      // Grant or deny, and update the counters.
      bcar_pkg::S_AUPD: begin
        pmem_raddr = i_r;
        pmem_we    = 1'b1;
        pmem_waddr = i_r;
        pmem_wdata = word_r;
        rmem_we    = 1'b1;
        rmem_wdata = {granted, bank_r};
        if (granted) begin
          bmem_we    = 1'b1;
          bmem_waddr = bank_r;
          bmem_wdata = 1'b1;
          pmem_wdata.wait_cnt = '0;
          if (word_r.grant_cnt != bcar_pkg::COUNT_MAX) begin
            pmem_wdata.grant_cnt = word_r.grant_cnt + 1'b1;
          end
        end else begin
          if (word_r.wait_cnt != bcar_pkg::COUNT_MAX) begin
            pmem_wdata.wait_cnt = word_r.wait_cnt + 1'b1;
          end
          if (!any_den_r) begin
            any_den_nxt = 1'b1;
            fd_nxt      = i_r;
          end
        end
        i_nxt   = i_last ? '0 : i_r + 1'b1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_last) begin
          k_nxt = '0;
          if (any_den_r) begin
            start_nxt = fd_r;
          end else if (!granted) begin
            start_nxt = i_r;
          end else begin
            start_nxt = start_eff;
          end
        end
      end

      bcar_pkg::S_ERD: begin
        pmem_raddr = k_r;
      end

      // Move one result into the output register and free its bank.
      bcar_pkg::S_ECAP: begin
        pmem_raddr = k_r;
        bmem_waddr = rmem_rdata[BW-1:0];
        if (cap) begin
          bmem_we       = rmem_rdata[BW];
          out_valid_nxt = 1'b1;
          out_idx_nxt   = bcar_pkg::IDX_W'(k_r);
          out_grant_nxt = rmem_rdata[BW];
          out_bank_nxt  = bcar_pkg::REQ_W'(rmem_rdata[BW-1:0]);
          out_wait_nxt  = rword.wait_cnt;
          out_gcnt_nxt  = rword.grant_cnt;
          out_last_nxt  = k_last;
          k_nxt         = k_r + 1'b1;
        end
      end

      default: begin
        pmem_raddr = pos_eff;
      end
    endcase
  end

  // Valid bits of the processor state memory.
  always_comb begin
    vld_nxt = vld_r;
    if (pmem_we) vld_nxt[pmem_waddr] = 1'b1;
    vld_q_nxt = vld_r[pmem_raddr];
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bcar_pkg::S_CLR;
      cfg_procs_r <= bcar_pkg::PROCS_RESET;
      cfg_banks_r <= bcar_pkg::BANKS_RESET;
      load_pos_r  <= '0;
      start_r     <= '0;
      i_r         <= '0;
      cnt_r       <= '0;
      k_r         <= '0;
      fd_r        <= '0;
      any_den_r   <= 1'b0;
      clr_r       <= '0;
      vld_r       <= '0;
      vld_q_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      load_pos_r  <= load_pos_nxt;
      start_r     <= start_nxt;
      i_r         <= i_nxt;
      cnt_r       <= cnt_nxt;
      k_r         <= k_nxt;
      fd_r        <= fd_nxt;
      any_den_r   <= any_den_nxt;
      clr_r       <= clr_nxt;
      vld_r       <= vld_nxt;
      vld_q_r     <= vld_q_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          bcar_pkg::CFG_PROCS: cfg_procs_r <= cfg_wdata[bcar_pkg::CFGP_W-1:0];
          bcar_pkg::CFG_BANKS: cfg_banks_r <= cfg_wdata;
          default: cfg_banks_r <= cfg_banks_r;
        endcase
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    word_r      <= word_nxt;
    bank_r      <= bank_nxt;
    out_idx_r   <= out_idx_nxt;
    out_grant_r <= out_grant_nxt;
    out_bank_r  <= out_bank_nxt;
    out_wait_r  <= out_wait_nxt;
    out_gcnt_r  <= out_gcnt_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign in_stall            = (state_r != bcar_pkg::S_LOAD);
  assign out_valid           = out_valid_r;
  assign out_processor_index = out_idx_r;
  assign out_grant           = out_grant_r;
  assign out_bank_used       = out_bank_r;
  assign out_wait_count      = out_wait_r;
  assign out_grant_count     = out_gcnt_r;
  assign out_last_result     = out_last_r;

endmodule

// ===== hw/rtl/bcar_checker.sv =====
`timescale 1ns / 1ps

module bcar_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [bcar_pkg::IDX_W-1:0] out_processor_index,
  input logic                       out_grant,
  input logic [bcar_pkg::CNT_W-1:0] out_wait_count,
  input logic [bcar_pkg::CNT_W-1:0] out_grant_count
);

  // No result is shown right after reset.
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // A stalled result holds.
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_processor_index)
      && $stable(out_wait_count))
    else $error("stalled result changed");

  // A granted processor has no wait and at least one grant.
  a_grant_counts: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_grant |-> out_wait_count == '0 && out_grant_count != '0)
    else $error("granted processor has inconsistent counts");

  // A denied processor has waited at least once.
  a_deny_counts: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_grant |-> out_wait_count != '0)
    else $error("denied processor has zero wait count");

endmodule

bind bank_conflict_arbiter_rotating_core bcar_checker u_bcar_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .out_valid           (out_valid),
  .out_stall           (out_stall),
  .out_processor_index (out_processor_index),
  .out_grant           (out_grant),
  .out_wait_count      (out_wait_count),
  .out_grant_count     (out_grant_count)
);

// ===== test/bank_conflict_arbiter_rotating_core_test.sv =====
`timescale 1ns / 1ps

module bank_conflict_arbiter_rotating_core_test;
  import bcar_pkg::*;

  localparam int NPROC = DEF_MAX_PROCESSORS;
  localparam int NBANK = DEF_MAX_BANKS;
  // Clearing pass after reset plus a wide margin over the slowest legal run.
  localparam int CYCLE_LIMIT = 1_000_000 + NBANK;
  // Cycles allowed for a load that produces no result to finish.
  localparam int SETTLE = 40;
  localparam logic [REQ_W-1:0] TOP_BANK = '1;

  // One per-processor arbitration result, in port order.
  typedef struct packed {
    logic [IDX_W-1:0] proc_idx;
    logic             grant;
    logic [REQ_W-1:0] bank;
    logic [CNT_W-1:0] waits;
    logic [CNT_W-1:0] grants;
    logic             last_flag;
  } grant_result_t;

  // Tracks the arbiter state and the queue of grant results still owed.
  class arbiter_scoreboard;
    logic [CFGP_W-1:0] procs_reg;
    logic [CFGB_W-1:0] banks_reg;
    logic [REQ_W-1:0]  held[NPROC];
    logic [CNT_W-1:0]  wait_cnt[NPROC];
    logic [CNT_W-1:0]  grant_cnt[NPROC];
    int unsigned       start_ptr;
    int unsigned       load_pos;
    grant_result_t     expected_grants[$];
    int                errors;
    int                checked;

    function new();
      procs_reg = PROCS_RESET;
      banks_reg = BANKS_RESET;
      foreach (held[i]) begin
        held[i] = '0;
        wait_cnt[i] = '0;
        grant_cnt[i] = '0;
      end
      start_ptr = 0;
      load_pos = 0;
      errors = 0;
      checked = 0;
    endfunction

    function int unsigned eff_procs();
      int unsigned p;
      p = 32'(procs_reg);
      if (p < 1) p = 1;
      if (p > NPROC) p = NPROC;
      return p;
    endfunction

    function int unsigned eff_banks();
      int unsigned b;
      b = 32'(banks_reg);
      if (b < 1) b = 1;
      if (b > NBANK) b = NBANK;
      return b;
    endfunction

    function void write_reg(input logic [CFGIDX_W-1:0] idx, input logic [CFGB_W-1:0] data);
      if (idx == CFG_PROCS) procs_reg = data[CFGP_W-1:0];
      else banks_reg = data;
    endfunction

    // Loads one request and, when the round closes, arbitrates it.
    function void note_request(input logic [REQ_W-1:0] bank, input logic eoc);
      int unsigned      procs, banks, pos, first_ptr, deny_idx, i, b, k;
      bit               any_denied;
      bit               busy[NBANK];
      bit               granted[NPROC];
      logic [REQ_W-1:0] used[NPROC];
      grant_result_t    r;
      procs = eff_procs();
      banks = eff_banks();
      pos = (load_pos >= procs) ? procs - 1 : load_pos;
      // A waiting processor keeps its old request.
      if (wait_cnt[pos] == '0) held[pos] = bank;
      if (!eoc && pos + 1 < procs) begin
        load_pos = pos + 1;
        return;
      end
      load_pos = 0;

      // Rotating pass over the processors, first come first served per bank.
      busy = '{default: 1'b0};
      first_ptr = (start_ptr >= procs) ? 0 : start_ptr;
      any_denied = 1'b0;
      deny_idx = 0;
      for (k = 0; k < procs; k++) begin
        i = first_ptr + k;
        if (i >= procs) i -= procs;
        b = (32'(held[i]) >= banks) ? banks - 1 : 32'(held[i]);
        used[i] = b[REQ_W-1:0];
        if (!busy[b]) begin
          busy[b] = 1'b1;
          granted[i] = 1'b1;
          wait_cnt[i] = '0;
          if (grant_cnt[i] != COUNT_MAX) grant_cnt[i]++;
        end else begin
          granted[i] = 1'b0;
          if (wait_cnt[i] != COUNT_MAX) wait_cnt[i]++;
          if (!any_denied) begin
            any_denied = 1'b1;
            deny_idx = i;
          end
        end
      end
      start_ptr = any_denied ? deny_idx : first_ptr;

      // Results come back in processor index order.
      for (k = 0; k < procs; k++) begin
        r.proc_idx = k[IDX_W-1:0];
        r.grant = granted[k];
        r.bank = used[k];
        r.waits = wait_cnt[k];
        r.grants = grant_cnt[k];
        r.last_flag = (k + 1 == procs);
        expected_grants.push_back(r);
      end
    endfunction

    function void compare_field(input string field, input int unsigned proc,
                                input int unsigned want, input int unsigned got);
      if (want != got) begin
        errors++;
        $display("%0t: %s mismatch for processor %0d: expected %0d, actual %0d",
                 $time, field, proc, want, got);
      end
    endfunction

    function void check_result(input grant_result_t got);
      grant_result_t want;
      int unsigned   pidx;
      checked++;
      if (expected_grants.size() == 0) begin
        errors++;
        $display("%0t: unexpected result for processor %0d: expected none, actual grant %0d",
                 $time, got.proc_idx, got.grant);
        return;
      end
      want = expected_grants.pop_front();
      pidx = 32'(want.proc_idx);
      compare_field("processor_index", pidx, pidx, 32'(got.proc_idx));
      compare_field("grant", pidx, 32'(want.grant), 32'(got.grant));
      compare_field("bank_used", pidx, 32'(want.bank), 32'(got.bank));
      compare_field("wait_count", pidx, 32'(want.waits), 32'(got.waits));
      compare_field("grant_count", pidx, 32'(want.grants), 32'(got.grants));
      compare_field("last_result", pidx, 32'(want.last_flag), 32'(got.last_flag));
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [CFGIDX_W-1:0] cfg_index;
  logic [CFGB_W-1:0]   cfg_wdata;
  logic                in_valid;
  logic                in_stall;
  logic [REQ_W-1:0]    in_bank_request;
  logic                in_end_of_cycle;
  logic                out_valid;
  logic                out_stall;
  logic [IDX_W-1:0]    out_processor_index;
  logic                out_grant;
  logic [REQ_W-1:0]    out_bank_used;
  logic [CNT_W-1:0]    out_wait_count;
  logic [CNT_W-1:0]    out_grant_count;
  logic                out_last_result;

  arbiter_scoreboard board;
  int                cycle_count = 0;
  int                send_idle_pct = 0;
  int                recv_idle_pct = 0;
  int                requests_sent = 0;
  int                settings = 0;

  bank_conflict_arbiter_rotating_core dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_bank_request     (in_bank_request),
    .in_end_of_cycle     (in_end_of_cycle),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_processor_index (out_processor_index),
    .out_grant           (out_grant),
    .out_bank_used       (out_bank_used),
    .out_wait_count      (out_wait_count),
    .out_grant_count     (out_grant_count),
    .out_last_result     (out_last_result)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Result monitor, random receiver stall and run watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (rst_n && out_valid && !out_stall)
      board.check_result({out_processor_index, out_grant, out_bank_used,
                          out_wait_count, out_grant_count, out_last_result});
    out_stall <= ($urandom_range(99) < recv_idle_pct);
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: watchdog expired with %0d results outstanding",
               $time, board.expected_grants.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  // Writes both registers on consecutive edges.
  task automatic write_config(input int unsigned procs_val, input int unsigned banks_val);
    cfg_we <= 1'b1;
    cfg_index <= CFG_PROCS;
    cfg_wdata <= procs_val[CFGB_W-1:0];
    @(posedge clk);
    board.write_reg(CFG_PROCS, procs_val[CFGB_W-1:0]);
    cfg_index <= CFG_BANKS;
    cfg_wdata <= banks_val[CFGB_W-1:0];
    @(posedge clk);
    board.write_reg(CFG_BANKS, banks_val[CFGB_W-1:0]);
    cfg_we <= 1'b0;
    settings++;
  endtask

  // Presents one request and returns on the edge that accepts it; valid stays up.
  task automatic send_request(input logic [REQ_W-1:0] bank, input logic eoc);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_bank_request <= bank;
    in_end_of_cycle <= eoc;
    do @(posedge clk); while (in_stall);
    board.note_request(bank, eoc);
    requests_sent++;
  endtask

  // Drops valid and waits until every owed result has arrived.
  task automatic drain();
    in_valid <= 1'b0;
    while (board.expected_grants.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Mostly in-range banks so that conflicts are common; sometimes any value.
  function automatic logic [REQ_W-1:0] pick_bank();
    int unsigned v;
    if ($urandom_range(99) < 70) v = $urandom_range(board.eff_banks() - 1, 0);
    else v = $urandom_range(NBANK - 1, 0);
    return v[REQ_W-1:0];
  endfunction

  // Small processor counts dominate; junk in the unused upper data bits.
  function automatic int unsigned pick_procs();
    int unsigned sel, v;
    sel = $urandom_range(99);
    if (sel < 6) v = $urandom_range(127, 64);
    else if (sel < 10) v = 0;
    else if (sel < 20) v = $urandom_range(20, 9);
    else v = $urandom_range(8, 1);
    return ($urandom_range(31) << CFGP_W) | v;
  endfunction

  function automatic int unsigned pick_banks();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 5) return 0;
    else if (sel < 40) return $urandom_range(4, 1);
    else if (sel < 65) return $urandom_range(64, 5);
    else if (sel < 85) return $urandom_range(NBANK - 1, 65);
    else return $urandom_range(4095, NBANK);
  endfunction

  // One round from the current load position: complete, closed by the last
  // processor alone, ended early, or left open.
  task automatic play_round();
    int unsigned procs, pos, n, stop, k, style;
    logic        ends;
    procs = board.eff_procs();
    pos = (board.load_pos >= procs) ? procs - 1 : board.load_pos;
    n = procs - pos;
    style = $urandom_range(99);
    stop = (style < 82) ? n : $urandom_range(n, 1);
    for (k = 0; k < stop; k++) begin
      ends = (style < 70 || (style >= 82 && style < 94)) && (k + 1 == stop);
      send_request(pick_bank(), ends);
    end
  endtask

  task automatic run_phase(input int send_pct, input int recv_pct, input int n_items);
    int target, rounds, r;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    target = requests_sent + n_items;
    while (requests_sent < target) begin
      drain();
      write_config(pick_procs(), pick_banks());
      rounds = (board.eff_procs() > 16) ? 1 : $urandom_range(6, 1);
      for (r = 0; r < rounds && requests_sent < target; r++) play_round();
    end
    drain();
  endtask

  initial begin
    board = new();
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= CFG_PROCS;
    cfg_wdata <= '0;
    in_valid <= 1'b0;
    in_bank_request <= '0;
    in_end_of_cycle <= 1'b0;
    out_stall <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    recv_idle_pct = 30;

    // Four processors fight over the lowest and highest banks.
    write_config(4, NBANK);
    send_request('0, 1'b0);
    send_request(TOP_BANK, 1'b0);
    send_request('0, 1'b0);
    send_request(TOP_BANK, 1'b1);
    // Waiting processors ignore new requests; the last one closes the round.
    send_request(REQ_W'(5), 1'b0);
    send_request(REQ_W'(6), 1'b0);
    send_request(REQ_W'(7), 1'b0);
    send_request(REQ_W'(8), 1'b0);
    // Early end of cycle after the first processor.
    send_request(REQ_W'(9), 1'b1);
    drain();

    // A single bank: every request is clamped onto it.
    write_config(3, 1);
    send_request(TOP_BANK, 1'b0);
    send_request(REQ_W'(1024), 1'b0);
    send_request('0, 1'b1);
    drain();

    // Shrink the processor count while a round is partly loaded.
    write_config(8, 4);
    repeat (5) send_request(pick_bank(), 1'b0);
    drain();
    write_config(2, 4);
    send_request(REQ_W'(3), 1'b0);
    drain();

    // One processor: every request is its own round.
    write_config(1, NBANK);
    send_request(TOP_BANK, 1'b1);
    send_request('0, 1'b0);
    drain();

    // Zero in both registers acts as one.
    write_config(0, 0);
    send_request(TOP_BANK, 1'b0);
    send_request(REQ_W'(1), 1'b1);
    drain();

    // Oversized registers saturate; an early end reports all processors.
    write_config((5'h15 << CFGP_W) | 127, 4095);
    send_request(TOP_BANK, 1'b1);
    drain();

    // Random rounds under three idle and stall mixes.
    run_phase(6, 70, 85);
    run_phase(70, 6, 85);
    run_phase(0, 0, 85);

    $display("Covered %0d requests and %0d per-processor results over %0d register settings,",
             requests_sent, board.checked, settings);
    $display("including saturated registers, clamped banks, early ends and partial rounds.");
    if (board.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/bcar_pkg.sv
hw/rtl/bcar_ram.sv
hw/rtl/bank_conflict_arbiter_rotating_core.sv
hw/rtl/bcar_checker.sv
test/bank_conflict_arbiter_rotating_core_test.sv
